// File: hdl/pptab_pkg.sv
package pptab_pkg;

  // default sizes
  localparam int PATH_MAX_DEF    = 64;
  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NOT_PERMITTED = 3'd1;
  localparam logic [2:0] ST_INVALID       = 3'd2;
  localparam logic [2:0] ST_TOO_LONG      = 3'd3;
  localparam logic [2:0] ST_NO_SPACE      = 3'd4;

  // commands
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  // register index (byte address / 4)
  localparam logic REG_TABLE_LOCKED = 1'b0;

  typedef struct packed {
    logic       cmd;
    logic [7:0] mask;
    logic       locked;
    logic       first_slash;
  } cmd_req_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] status;
  } result_t;

endpackage

// File: hdl/path_prefix_permission_table_unit.sv
// Path prefix permission table.
// Operation: a closing request starts a command, and its result returns through
// the output register; each compared or copied byte passes a read state and then
// a compare or write state through the entry byte memory.
// Throughput: one byte per cycle while no command runs; none during a command.
// Reset (rst, synchronous): empties the table, clears the path and the lock.
module path_prefix_permission_table_unit #(
  parameter int PATH_MAX    = pptab_pkg::PATH_MAX_DEF,
  parameter int MAX_ENTRIES = pptab_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  path_byte,
  input  logic        last_byte,
  input  logic [7:0]  perm_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        allowed,
  output logic [2:0]  status
);
  import pptab_pkg::*;

  localparam int LW = $clog2(PATH_MAX + 1);
  localparam int PW = $clog2(PATH_MAX);

  logic          table_locked;
  logic [LW-1:0] path_length;
  logic          string_ended;
  logic          first_slash;
  logic [7:0]    path_buffer [PATH_MAX];
  logic [7:0]    pb_rdata;
  logic [PW-1:0] pb_raddr;
  logic          accept;
  logic          take;
  logic [LW-1:0] plen_next;
  logic          first_slash_next;
  logic          busy;
  logic          res_valid;
  logic          res_ready;
  cmd_req_t      req;
  result_t       res;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TABLE_LOCKED) ? {31'b0, table_locked} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_locked <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_TABLE_LOCKED) begin
      table_locked <= pwdata[0];
    end
  end

  // path collection
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign take     = !string_ended && path_byte != 8'd0 && path_length < LW'(PATH_MAX);
  assign plen_next = take ? path_length + 1'b1 : path_length;
  assign first_slash_next = (take && path_length == '0) ? (path_byte == SLASH_CHAR)
                                                        : first_slash;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_length  <= '0;
      string_ended <= 1'b0;
      first_slash  <= 1'b0;
    end else if (accept) begin
      first_slash <= first_slash_next;
      if (last_byte) begin
        path_length  <= '0;
        string_ended <= 1'b0;
      end else begin
        path_length <= plen_next;
        if (!string_ended && path_byte == 8'd0) begin
          string_ended <= 1'b1;
        end
      end
    end
  end

  // path buffer memory
  always_ff @(posedge clk) begin
    pb_rdata <= path_buffer[pb_raddr];
    if (accept && take) begin
      path_buffer[path_length[PW-1:0]] <= path_byte;
    end
  end

  assign req = '{cmd: cmd, mask: perm_mask, locked: table_locked,
                 first_slash: first_slash_next};

  pptab_engine #(
    .PATH_MAX   (PATH_MAX),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && last_byte),
    .req      (req),
    .plen     (plen_next),
    .pb_rdata (pb_rdata),
    .pb_raddr (pb_raddr),
    .busy     (busy),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
      allowed   <= res.allowed;
      status    <= res.status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    path_length <= LW'(PATH_MAX))
    else $error("path length beyond limit");

  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> !in_ready && path_length == '0)
    else $error("command did not start");

  a_res_load: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> out_valid)
    else $error("result lost");

  a_check_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.allowed |-> res.status == ST_OK)
    else $error("allowed with error status");

endmodule

// File: hdl/pptab_engine.sv
module pptab_engine #(
  parameter int PATH_MAX    = pptab_pkg::PATH_MAX_DEF,
  parameter int MAX_ENTRIES = pptab_pkg::MAX_ENTRIES_DEF,
  parameter int LW = $clog2(PATH_MAX + 1),
  parameter int PW = $clog2(PATH_MAX)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pptab_pkg::cmd_req_t req,
  input  logic [LW-1:0]       plen,
  input  logic [7:0]          pb_rdata,
  output logic [PW-1:0]       pb_raddr,
  output logic                busy,
  output logic                res_valid,
  input  logic                res_ready,
  output pptab_pkg::result_t  res
);
  import pptab_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AW = (MAX_ENTRIES * PATH_MAX > 1) ? $clog2(MAX_ENTRIES * PATH_MAX) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ENTRY  = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_SL_RD  = 4'd4;
  localparam logic [3:0] S_SL_CMP = 4'd5;
  localparam logic [3:0] S_CP_RD  = 4'd6;
  localparam logic [3:0] S_CP_WR  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]    state;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic [LW-1:0] j;
  logic [LW-1:0] el;
  logic [LW-1:0] plen_r;
  cmd_req_t      req_r;
  result_t       res_r;

  // entry storage
  logic [7:0]    entry_bytes [MAX_ENTRIES*PATH_MAX];
  logic [LW-1:0] entry_len   [MAX_ENTRIES];
  logic [7:0]    entry_perm  [MAX_ENTRIES];
  logic [7:0]    eb_rdata;
  logic [AW-1:0] eb_addr;
  logic [IW-1:0] ent;
  logic [IW-1:0] cur;
  logic [LW-1:0] cur_len;
  logic          cand;

  assign cur     = idx[IW-1:0];
  assign cur_len = entry_len[cur];
  assign ent     = (state == S_CP_WR) ? count[IW-1:0] : cur;
  assign eb_addr = AW'(ent) * AW'(PATH_MAX) + AW'(j);
  assign pb_raddr = (state == S_SL_RD || state == S_SL_CMP) ? el[PW-1:0] : j[PW-1:0];
  assign cand = (req_r.cmd == CMD_ADD) ? (cur_len == plen_r) : (cur_len <= plen_r);

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_r;

  // byte store: one read, one write port
  always_ff @(posedge clk) begin
    eb_rdata <= entry_bytes[eb_addr];
    if (state == S_CP_WR) begin
      entry_bytes[eb_addr] <= pb_rdata;
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
      j     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req_r  <= req;
            plen_r <= plen;
            idx    <= '0;
            if (req.cmd == CMD_ADD) begin
              if (req.locked) begin
                res_r <= '{allowed: 1'b0, status: ST_NOT_PERMITTED};
                state <= S_DONE;
              end else if (plen == '0 || !req.first_slash) begin
                res_r <= '{allowed: 1'b0, status: ST_INVALID};
                state <= S_DONE;
              end else if (plen >= LW'(PATH_MAX)) begin
                res_r <= '{allowed: 1'b0, status: ST_TOO_LONG};
                state <= S_DONE;
              end else begin
                res_r <= '{allowed: 1'b0, status: ST_OK};
                state <= S_ENTRY;
              end
            end else if (count == '0) begin
              res_r <= '{allowed: 1'b1, status: ST_OK};
              state <= S_DONE;
            end else begin
              res_r <= '{allowed: 1'b0, status: ST_OK};
              state <= S_ENTRY;
            end
          end
        end
        S_ENTRY: begin
          if (idx == count) begin
            if (req_r.cmd == CMD_ADD) begin
              if (count == CW'(MAX_ENTRIES)) begin
                res_r.status <= ST_NO_SPACE;
                state <= S_DONE;
              end else begin
                j <= '0;
                state <= S_CP_RD;
              end
            end else begin
              res_r.allowed <= 1'b0;
              state <= S_DONE;
            end
          end else if (cand) begin
            el <= cur_len;
            j  <= '0;
            state <= S_RD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (eb_rdata != pb_rdata) begin
            idx <= idx + 1'b1;
            state <= S_ENTRY;
          end else if (j == el - 1'b1) begin
            if (req_r.cmd == CMD_ADD) begin
              entry_perm[cur] <= entry_perm[cur] | req_r.mask;
              state <= S_DONE;
            end else if (plen_r > el) begin
              state <= S_SL_RD;
            end else begin
              res_r.allowed <= ((entry_perm[cur] & req_r.mask) == req_r.mask);
              state <= S_DONE;
            end
          end else begin
            j <= j + 1'b1;
            state <= S_RD;
          end
        end
        S_SL_RD: begin
          state <= S_SL_CMP;
        end
        S_SL_CMP: begin
          if (pb_rdata == SLASH_CHAR) begin
            res_r.allowed <= ((entry_perm[cur] & req_r.mask) == req_r.mask);
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_ENTRY;
          end
        end
        S_CP_RD: begin
          state <= S_CP_WR;
        end
        S_CP_WR: begin
          if (j == plen_r - 1'b1) begin
            entry_len[count[IW-1:0]]  <= plen_r;
            entry_perm[count[IW-1:0]] <= req_r.mask;
            count <= count + 1'b1;
            state <= S_DONE;
          end else begin
            j <= j + 1'b1;
            state <= S_CP_RD;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/path_prefix_permission_table_unit_test.sv
module path_prefix_permission_table_unit_test;
  import pptab_pkg::*;

  localparam int PMAX = PATH_MAX_DEF;
  localparam int NENT = MAX_ENTRIES_DEF;
  localparam int SETTLE = 2 * NENT * PMAX + 50;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic        cmd;
  logic [7:0]  path_byte;
  logic        last_byte;
  logic [7:0]  perm_mask;
  logic        out_valid, out_ready;
  logic        allowed;
  logic [2:0]  status;

  path_prefix_permission_table_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .path_byte(path_byte), .last_byte(last_byte), .perm_mask(perm_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .allowed(allowed), .status(status)
  );

  // Predictor state
  logic       lock_q;
  logic [7:0] pbuf [PMAX];
  int         plen;
  logic       pended;
  logic [7:0] tbl_bytes [NENT][PMAX];
  int         tbl_len [NENT];
  logic [7:0] tbl_perm [NENT];
  int         tbl_cnt;

  result_t    verdicts_q [$];
  int         errors;
  int         burst_left;

  // Stored paths for building well-formed requests
  string      known_paths [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 3000000);
    $display("status: fail");
    $finish;
  end

  function automatic logic prefix_hit(int e);
    int j;
    for (j = 0; j < tbl_len[e]; j++)
      if (tbl_bytes[e][j] != pbuf[j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [2:0] predict_add(logic [7:0] m);
    int i;
    if (lock_q) return ST_NOT_PERMITTED;
    if (plen == 0 || pbuf[0] != SLASH_CHAR) return ST_INVALID;
    if (plen >= PMAX) return ST_TOO_LONG;
    for (i = 0; i < tbl_cnt; i++)
      if (tbl_len[i] == plen && prefix_hit(i)) begin
        tbl_perm[i] |= m;
        return ST_OK;
      end
    if (tbl_cnt >= NENT) return ST_NO_SPACE;
    for (i = 0; i < plen; i++) tbl_bytes[tbl_cnt][i] = pbuf[i];
    tbl_len[tbl_cnt] = plen;
    tbl_perm[tbl_cnt] = m;
    tbl_cnt++;
    return ST_OK;
  endfunction

  function automatic logic predict_check(logic [7:0] need);
    int i;
    if (tbl_cnt == 0) return 1'b1;
    for (i = 0; i < tbl_cnt; i++) begin
      if (plen < tbl_len[i]) continue;
      if (!prefix_hit(i)) continue;
      if (plen > tbl_len[i] && pbuf[tbl_len[i]] != SLASH_CHAR) continue;
      return (tbl_perm[i] & need) == need;
    end
    return 1'b0;
  endfunction

  // Update predictor with one accepted request
  function automatic void predict_request(logic c, logic [7:0] b, logic l, logic [7:0] m);
    result_t r;
    if (!pended) begin
      if (b == 8'd0) pended = 1'b1;
      else if (plen < PMAX) begin
        pbuf[plen] = b;
        plen++;
      end
    end
    if (!l) return;
    if (c == CMD_ADD) begin
      r.allowed = 1'b0;
      r.status = predict_add(m);
    end else begin
      r.allowed = predict_check(m);
      r.status = ST_OK;
    end
    verdicts_q.push_back(r);
    plen = 0;
    pended = 1'b0;
  endfunction

  // Send one request, with bursty gaps; valid drops only during a gap
  task automatic send_request(logic c, logic [7:0] b, logic l, logic [7:0] m);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (g != 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    path_byte <= b;
    last_byte <= l;
    perm_mask <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(c, b, l, m);
  endtask

  // Send a whole path; the closing byte may carry the final character
  task automatic send_path(logic c, string s, logic [7:0] m, logic term);
    int i;
    int n;
    n = s.len();
    if (n == 0) begin
      send_request(c, 8'd0, 1'b1, m);
      return;
    end
    for (i = 0; i < n - 1; i++) send_request(c, s[i], 1'b0, 8'($urandom_range(0, 255)));
    if (term) begin
      send_request(c, s[n-1], 1'b0, 8'($urandom_range(0, 255)));
      send_request(c, 8'd0, 1'b1, m);
    end else begin
      send_request(c, s[n-1], 1'b1, m);
    end
  endtask

  task automatic wait_idle();
    int t;
    in_valid <= 1'b0;
    t = 0;
    while (verdicts_q.size() != 0 && t < 200000) begin
      @(posedge clk);
      t++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_lock(logic v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_TABLE_LOCKED, 2'b00}; pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    lock_q = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic string rand_segment();
    string s;
    int n;
    int i;
    byte ch;
    n = $urandom_range(1, 3);
    s = "";
    for (i = 0; i < n; i++) begin
      ch = byte'($urandom_range(0, 3) + 8'h61);
      s = {s, string'(ch)};
    end
    return s;
  endfunction

  function automatic string rand_path();
    string s;
    int k;
    int i;
    if (known_paths.size() != 0 && $urandom_range(0, 2) != 0) begin
      s = known_paths[$urandom_range(0, known_paths.size() - 1)];
      case ($urandom_range(0, 3))
        0: s = {s, "/", rand_segment()};
        1: s = {s, rand_segment()};
        default: ;
      endcase
      return s;
    end
    s = "";
    k = $urandom_range(1, 3);
    for (i = 0; i < k; i++) s = {s, "/", rand_segment()};
    return s;
  endfunction

  // Directed: extremes, empty table, errors, merge, lock
  task automatic test_directed();
    string longp;
    int i;
    send_path(CMD_CHECK, "/x", 8'hFF, 1'b1);
    send_path(CMD_ADD, "", 8'h01, 1'b0);
    send_path(CMD_ADD, "abc", 8'h01, 1'b1);
    send_path(CMD_ADD, "/a", 8'h03, 1'b0);
    send_path(CMD_ADD, "/a", 8'h80, 1'b1);
    send_path(CMD_CHECK, "/a/b", 8'h83, 1'b0);
    send_path(CMD_CHECK, "/ab", 8'h01, 1'b1);
    send_path(CMD_CHECK, "/a", 8'h00, 1'b1);
    // bytes after a terminator, then a non-zero closing byte
    send_request(CMD_CHECK, SLASH_CHAR, 1'b0, 8'h00);
    send_request(CMD_CHECK, 8'h61, 1'b0, 8'h00);
    send_request(CMD_CHECK, 8'h00, 1'b0, 8'h00);
    send_request(CMD_CHECK, 8'hFF, 1'b0, 8'h00);
    send_request(CMD_CHECK, 8'h7A, 1'b1, 8'h01);
    // over-long path on add and on check
    longp = "/a";
    for (i = 0; i < PMAX + 4; i++) longp = {longp, "z"};
    send_path(CMD_ADD, longp, 8'hFF, 1'b0);
    longp = "/a/";
    for (i = 0; i < PMAX + 4; i++) longp = {longp, "q"};
    send_path(CMD_CHECK, longp, 8'h02, 1'b1);
    known_paths.push_back("/a");
    wait_idle();
    write_lock(1'b1);
    send_path(CMD_ADD, "/b", 8'h01, 1'b0);
    send_path(CMD_CHECK, "/a", 8'h01, 1'b0);
    wait_idle();
    write_lock(1'b0);
  endtask

  // Fill the table to capacity and beyond
  task automatic test_full_table();
    int i;
    string s;
    for (i = 0; i < NENT + 2; i++) begin
      s = {"/f", string'(byte'(8'h41 + i))};
      send_path(CMD_ADD, s, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if (i < NENT) known_paths.push_back(s);
    end
    send_path(CMD_ADD, "/a", 8'h10, 1'b1);
    send_path(CMD_CHECK, "/fB/x", 8'hFF, 1'b0);
    send_path(CMD_CHECK, "/zz", 8'h00, 1'b1);
  endtask

  // Random: mostly well-formed paths, some noise
  task automatic test_random(int budget);
    int sent;
    int i;
    int n;
    string s;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
          send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), i == n - 1,
                       8'($urandom_range(0, 255)));
        sent += n;
      end else begin
        s = rand_path();
        send_path($urandom_range(0, 3) == 0, s, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        sent += s.len() + 1;
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (verdicts_q.size() == 0) begin
        $error("unexpected result allowed=%0d status=%0d", allowed, status);
        errors++;
      end else begin
        exp_r = verdicts_q.pop_front();
        if (allowed !== exp_r.allowed) begin
          $error("allowed: expected %0d actual %0d", exp_r.allowed, allowed);
          errors++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, status);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 99) == 0);
  end

  initial begin
    errors = 0;
    burst_left = 0;
    lock_q = 1'b0;
    plen = 0;
    pended = 1'b0;
    tbl_cnt = 0;
    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid <= 1'b0; cmd <= 1'b0; path_byte <= 8'd0; last_byte <= 1'b0; perm_mask <= 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_full_table();
    test_random(600);
    wait_idle();
    write_lock(1'b1);
    test_random(250);
    wait_idle();
    write_lock(1'b0);
    test_random(450);
    wait_idle();
    if (errors == 0 && verdicts_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (verdicts_q.size() != 0) $error("%0d results never arrived", verdicts_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
